>>> design/dfla_pkg.sv
// Shared constants, codes and control types for the descriptor free list allocator.
`default_nettype none
package dfla_pkg;

  localparam int DEF_MAX_SLOTS = 64;

  localparam int HANDLE_W = 64;
  localparam int INC_W    = 16;
  localparam int COUNT_W  = 7;
  localparam int IDX_W    = 7;
  localparam int OUT_IDX_W = 6;
  localparam int PROD_W   = IDX_W + INC_W;
  localparam int CFG_IDX_W = 2;
  localparam int STATUS_W = 2;

  localparam int DIV_BITS_PER_STEP = 2;
  localparam int DIV_STEPS = HANDLE_W / DIV_BITS_PER_STEP;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INCREMENT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT     = 2'd3;

  localparam logic [INC_W-1:0]   RST_INCREMENT = 16'd32;
  localparam logic [COUNT_W-1:0] RST_COUNT     = 7'd64;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] EMIT_ALLOC = 2'd0;
  localparam logic [1:0] EMIT_FREE  = 2'd1;
  localparam logic [1:0] EMIT_FAIL  = 2'd2;

  typedef struct packed {
    logic                capture;
    logic                pop;
    logic                fresh;
    logic                mul;
    logic                add;
    logic                div_init;
    logic                div_step;
    logic                push;
    logic                emit;
    logic [1:0]          emit_kind;
    logic [STATUS_W-1:0] emit_status;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic freed_nonempty;
    logic fresh_avail;
    logic inc_zero;
    logic quot_equal;
    logic quot_in_range;
    logic stack_full;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> design/dfla_datapath.sv
// Datapath: configuration registers, slot stack memory, handle arithmetic and radix-4 divider.
`default_nettype none
module dfla_datapath import dfla_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [HANDLE_W-1:0]  cfg_data,
  input  wire logic                 op,
  input  wire logic [HANDLE_W-1:0]  cpu_handle_in,
  input  wire logic [HANDLE_W-1:0]  gpu_handle_in,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [HANDLE_W-1:0]       cpu_handle_out,
  output logic [HANDLE_W-1:0]       gpu_handle_out,
  output logic [OUT_IDX_W-1:0]      slot_index,
  output logic [STATUS_W-1:0]       status
);

  localparam int AW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int DW  = $clog2(MAX_SLOTS + 1);
  localparam int CAP = (MAX_SLOTS > 127) ? 127 : MAX_SLOTS;

  logic [HANDLE_W-1:0] cpu_base;
  logic [HANDLE_W-1:0] gpu_base;
  logic [INC_W-1:0]    inc;
  logic [COUNT_W-1:0]  count_cfg;

  logic                op_q;
  logic [HANDLE_W-1:0] cpu_q;
  logic [HANDLE_W-1:0] gpu_q;
  logic [HANDLE_W-1:0] cpu_q_next;
  logic [HANDLE_W-1:0] gpu_q_next;
  logic [INC_W-1:0]    cpu_rem;
  logic [INC_W-1:0]    gpu_rem;
  logic [INC_W-1:0]    cpu_rem_next;
  logic [INC_W-1:0]    gpu_rem_next;

  logic [IDX_W-1:0]    idx;
  logic [PROD_W-1:0]   prod;
  logic [HANDLE_W-1:0] res_cpu;
  logic [HANDLE_W-1:0] res_gpu;

  logic [IDX_W-1:0]    mem [MAX_SLOTS];
  logic [DW-1:0]       freed_depth;
  logic [DW-1:0]       depth_m1;
  logic [IDX_W-1:0]    fresh;
  logic [IDX_W-1:0]    eff;

  logic [INC_W:0]      c1;
  logic [INC_W:0]      c2;
  logic [INC_W:0]      g1;
  logic [INC_W:0]      g2;

  function automatic logic [INC_W:0] div_bit(input logic [INC_W-1:0] rem,
                                             input logic nb,
                                             input logic [INC_W-1:0] d);
    logic [INC_W:0] part;
    logic [INC_W:0] diff;
    part = {rem, nb};
    diff = part - {1'b0, d};
    if (part >= {1'b0, d}) begin
      return {1'b1, diff[INC_W-1:0]};
    end else begin
      return {1'b0, part[INC_W-1:0]};
    end
  endfunction

  assign eff      = (count_cfg > IDX_W'(CAP)) ? IDX_W'(CAP) : count_cfg;
  assign depth_m1 = freed_depth - DW'(1);

  always_comb begin
    c1 = div_bit(cpu_rem, cpu_q[HANDLE_W-1], inc);
    c2 = div_bit(c1[INC_W-1:0], cpu_q[HANDLE_W-2], inc);
    g1 = div_bit(gpu_rem, gpu_q[HANDLE_W-1], inc);
    g2 = div_bit(g1[INC_W-1:0], gpu_q[HANDLE_W-2], inc);
    cpu_q_next   = {cpu_q[HANDLE_W-3:0], c1[INC_W], c2[INC_W]};
    gpu_q_next   = {gpu_q[HANDLE_W-3:0], g1[INC_W], g2[INC_W]};
    cpu_rem_next = c2[INC_W-1:0];
    gpu_rem_next = g2[INC_W-1:0];
  end

  always_comb begin
    sts.op             = op_q;
    sts.freed_nonempty = (freed_depth != '0);
    sts.fresh_avail    = (fresh < eff);
    sts.inc_zero       = (inc == '0);
    sts.quot_equal     = (cpu_q == gpu_q);
    sts.quot_in_range  = (cpu_q[HANDLE_W-1:IDX_W] == '0) && (cpu_q[IDX_W-1:0] < eff);
    sts.stack_full     = (freed_depth == DW'(MAX_SLOTS));
    sts.out_free       = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_base  <= '0;
      gpu_base  <= '0;
      inc       <= RST_INCREMENT;
      count_cfg <= RST_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CPU_BASE:  cpu_base  <= cfg_data;
        CFG_GPU_BASE:  gpu_base  <= cfg_data;
        CFG_INCREMENT: inc       <= cfg_data[INC_W-1:0];
        CFG_COUNT:     count_cfg <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freed_depth <= '0;
      fresh       <= '0;
    end else begin
      if (cmd.pop) begin
        freed_depth <= depth_m1;
      end else if (cmd.push) begin
        freed_depth <= freed_depth + DW'(1);
      end
      if (cmd.fresh) begin
        fresh <= fresh + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[freed_depth[AW-1:0]] <= cpu_q[IDX_W-1:0];
    end
    if (cmd.pop) begin
      idx <= mem[depth_m1[AW-1:0]];
    end else if (cmd.fresh) begin
      idx <= fresh;
    end else if (cmd.push) begin
      idx <= cpu_q[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= op;
      cpu_q <= cpu_handle_in;
      gpu_q <= gpu_handle_in;
    end else if (cmd.div_init) begin
      cpu_q   <= cpu_q - cpu_base;
      gpu_q   <= gpu_q - gpu_base;
      cpu_rem <= '0;
      gpu_rem <= '0;
    end else if (cmd.div_step) begin
      cpu_q   <= cpu_q_next;
      gpu_q   <= gpu_q_next;
      cpu_rem <= cpu_rem_next;
      gpu_rem <= gpu_rem_next;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(idx) * PROD_W'(inc);
    end
    if (cmd.add) begin
      res_cpu <= cpu_base + HANDLE_W'(prod);
      res_gpu <= gpu_base + HANDLE_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cpu_handle_out <= (cmd.emit_kind == EMIT_ALLOC) ? res_cpu : '0;
      gpu_handle_out <= (cmd.emit_kind == EMIT_ALLOC) ? res_gpu : '0;
      slot_index     <= (cmd.emit_kind == EMIT_FAIL) ? '0 : idx[OUT_IDX_W-1:0];
      status         <= cmd.emit_status;
    end
  end

endmodule
`default_nettype wire

>>> design/dfla_ctrl.sv
// Controller state machine that sequences allocate and free requests through the datapath.
`default_nettype none
module dfla_ctrl import dfla_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_ADD    = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_CHECK  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_CNT_W-1:0] cnt_next;
  logic [1:0]           pend_kind;
  logic [1:0]           pend_kind_next;
  logic [STATUS_W-1:0]  pend_status;
  logic [STATUS_W-1:0]  pend_status_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd              = '0;
    state_next       = state;
    cnt_next         = cnt;
    pend_kind_next   = pend_kind;
    pend_status_next = pend_status;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.op == OP_ALLOC) begin
          if (sts.freed_nonempty) begin
            cmd.pop    = 1'b1;
            state_next = S_MUL;
          end else if (sts.fresh_avail) begin
            cmd.fresh  = 1'b1;
            state_next = S_MUL;
          end else begin
            pend_kind_next   = EMIT_FAIL;
            pend_status_next = ST_NO_FREE;
            state_next       = S_EMIT;
          end
        end else if (sts.inc_zero) begin
          pend_kind_next   = EMIT_FAIL;
          pend_status_next = ST_RANGE;
          state_next       = S_EMIT;
        end else begin
          cmd.div_init = 1'b1;
          cnt_next     = '0;
          state_next   = S_DIV;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add          = 1'b1;
        pend_kind_next   = EMIT_ALLOC;
        pend_status_next = ST_OK;
        state_next       = S_EMIT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (!sts.quot_equal) begin
          pend_kind_next   = EMIT_FAIL;
          pend_status_next = ST_MISMATCH;
        end else if (!sts.quot_in_range || sts.stack_full) begin
          pend_kind_next   = EMIT_FAIL;
          pend_status_next = ST_RANGE;
        end else begin
          cmd.push         = 1'b1;
          pend_kind_next   = EMIT_FREE;
          pend_status_next = ST_OK;
        end
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_kind   = pend_kind;
          cmd.emit_status = pend_status;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      pend_kind   <= EMIT_FAIL;
      pend_status <= ST_OK;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      pend_kind   <= pend_kind_next;
      pend_status <= pend_status_next;
    end
  end

endmodule
`default_nettype wire

>>> design/descriptor_free_list_allocator.sv
// Top level of the descriptor free list allocator: controller plus datapath.
// Allocate: decide, multiply, add, then emit; with no free slot, decide goes straight to emit.
// Free: decide, radix-4 divider steps, check, then emit; a zero increment skips to emit.
// One request is in flight at a time; the next is taken the cycle after its result is loaded.
// Synchronous active-high reset empties the freed stack, restarts fresh slots at zero,
// and restores the configuration registers to their defaults.
`default_nettype none
module descriptor_free_list_allocator import dfla_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [HANDLE_W-1:0]  cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 op,
  input  wire logic [HANDLE_W-1:0]  cpu_handle_in,
  input  wire logic [HANDLE_W-1:0]  gpu_handle_in,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [HANDLE_W-1:0]       cpu_handle_out,
  output logic [HANDLE_W-1:0]       gpu_handle_out,
  output logic [OUT_IDX_W-1:0]      slot_index,
  output logic [STATUS_W-1:0]       status
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  dfla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dfla_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .op             (op),
    .cpu_handle_in  (cpu_handle_in),
    .gpu_handle_in  (gpu_handle_in),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cpu_handle_out (cpu_handle_out),
    .gpu_handle_out (gpu_handle_out),
    .slot_index     (slot_index),
    .status         (status)
  );

endmodule
`default_nettype wire

>>> design/dfla_checker.sv
// Port-level checker for the descriptor free list allocator and its bind statement.
`default_nettype none
module dfla_checker import dfla_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [HANDLE_W-1:0]  cpu_handle_out,
  input wire logic [HANDLE_W-1:0]  gpu_handle_out,
  input wire logic [OUT_IDX_W-1:0] slot_index,
  input wire logic [STATUS_W-1:0]  status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_index)
      && $stable(cpu_handle_out) && $stable(gpu_handle_out))
    else $error("Result beat changed while stalled.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> cpu_handle_out == '0 && gpu_handle_out == '0
      && slot_index == '0)
    else $error("Failed request returned nonzero fields.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Second request taken while one is in flight.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result beat pending after reset.");

endmodule

bind descriptor_free_list_allocator dfla_checker u_dfla_checker (.*);
`default_nettype wire
